// ----- rtl/nps_pkg.sv -----
// shared constants and types for the nine-patch rectangle splitter
package nps_pkg;

	localparam int COORD_BITS = 16;
	localparam int FRAME_BITS = 15;
	localparam int IN_W       = 16;
	localparam int OUT_W      = COORD_BITS + 1;
	localparam int EDGE_W     = COORD_BITS + 2;
	localparam int NUM_W      = COORD_BITS + FRAME_BITS;
	localparam int DEN_W      = FRAME_BITS + 1;
	localparam int DIV_SPS    = 2;
	localparam int DIV_STAGES = (COORD_BITS + DIV_SPS - 1) / DIV_SPS;
	localparam int VLD_N      = DIV_STAGES + 4;

	localparam int PATCH_COUNT = 9;
	localparam int IDX_W       = 4;
	localparam int IN_FIELDS   = 8;
	localparam int IN_DATA_W   = IN_FIELDS * IN_W;
	localparam int OUT_RAW_W   = IDX_W + 8 * OUT_W;
	localparam int OUT_DATA_W  = ((OUT_RAW_W + 7) / 8) * 8;
	localparam int PAD_W       = OUT_DATA_W - OUT_RAW_W;

	localparam int ADDR_W = 4;
	localparam int APB_W  = 32;

	typedef logic signed [EDGE_W-1:0] edge_t;
	typedef logic [COORD_BITS-1:0]    quo_t;
	typedef logic [FRAME_BITS-1:0]    frame_t;

	typedef enum logic [1:0] {
		REG_FRAME_LEFT   = 2'd0,
		REG_FRAME_TOP    = 2'd1,
		REG_FRAME_RIGHT  = 2'd2,
		REG_FRAME_BOTTOM = 2'd3
	} reg_idx_t;

	typedef struct packed {
		frame_t left;
		frame_t top;
		frame_t right;
		frame_t bottom;
	} frames_t;

	typedef struct packed {
		edge_t e0;
		edge_t e1;
		edge_t e2;
		edge_t e3;
		logic  fold;
		logic  zero_sum;
	} axis_t;

	typedef struct packed {
		logic  empty;
		axis_t sx;
		axis_t sy;
		axis_t dx;
		axis_t dy;
	} grid_t;

endpackage

// ----- rtl/nps_front.sv -----
// input register, grid edges and fold-point products (stages s1 to s3)
module nps_front (
	input  logic                          clk,
	input  logic                          en,
	input  logic [nps_pkg::IN_DATA_W-1:0] in_data,
	input  nps_pkg::frames_t              frames,
	output nps_pkg::grid_t                grid_s3,
	output logic [nps_pkg::NUM_W-1:0]     num_x_s3,
	output logic [nps_pkg::NUM_W-1:0]     num_y_s3,
	output logic [nps_pkg::DEN_W-1:0]     den_x_s3,
	output logic [nps_pkg::DEN_W-1:0]     den_y_s3
);
	import nps_pkg::*;

	edge_t crd_s1 [IN_FIELDS];
	grid_t grid_c;
	grid_t grid_s2;
	quo_t  span_x_c;
	quo_t  span_y_c;
	quo_t  span_x_s2;
	quo_t  span_y_s2;

	function automatic edge_t sext_in(input logic [IN_W-1:0] v);
		logic signed [COORD_BITS-1:0] c;
		c = signed'(v[COORD_BITS-1:0]);
		return edge_t'(c);
	endfunction

	function automatic axis_t make_axis(input edge_t lo, input edge_t hi,
			input frame_t a, input frame_t b, input logic may_fold);
		axis_t r;
		r.e0 = lo;
		r.e1 = lo + edge_t'(a);
		r.e2 = hi - edge_t'(b);
		r.e3 = hi;
		r.fold = may_fold && (r.e1 > r.e2);
		r.zero_sum = (a == '0) && (b == '0);
		return r;
	endfunction

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < IN_FIELDS; i++) begin
				crd_s1[i] <= sext_in(in_data[i*IN_W +: IN_W]);
			end
		end
	end

	always_comb begin
		grid_c.empty = (crd_s1[2] <= crd_s1[0]) || (crd_s1[3] <= crd_s1[1]) ||
			(crd_s1[6] <= crd_s1[4]) || (crd_s1[7] <= crd_s1[5]);
		grid_c.sx = make_axis(crd_s1[0], crd_s1[2], frames.left, frames.right, 1'b0);
		grid_c.sy = make_axis(crd_s1[1], crd_s1[3], frames.top, frames.bottom, 1'b0);
		grid_c.dx = make_axis(crd_s1[4], crd_s1[6], frames.left, frames.right, 1'b1);
		grid_c.dy = make_axis(crd_s1[5], crd_s1[7], frames.top, frames.bottom, 1'b1);
		span_x_c = quo_t'(crd_s1[6] - crd_s1[4]);
		span_y_c = quo_t'(crd_s1[7] - crd_s1[5]);
	end

	always_ff @(posedge clk) begin
		if (en) begin
			grid_s2   <= grid_c;
			span_x_s2 <= span_x_c;
			span_y_s2 <= span_y_c;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			grid_s3  <= grid_s2;
			num_x_s3 <= NUM_W'(span_x_s2) * NUM_W'(frames.left);
			num_y_s3 <= NUM_W'(span_y_s2) * NUM_W'(frames.top);
			den_x_s3 <= DEN_W'(frames.left) + DEN_W'(frames.right);
			den_y_s3 <= DEN_W'(frames.top) + DEN_W'(frames.bottom);
		end
	end

endmodule

// ----- rtl/nps_div.sv -----
// pipelined restoring divider, two quotient bits per stage
module nps_div (
	input  logic                      clk,
	input  logic                      en,
	input  logic [nps_pkg::NUM_W-1:0] dividend,
	input  logic [nps_pkg::DEN_W-1:0] divisor,
	output nps_pkg::quo_t             quotient
);
	import nps_pkg::*;

	logic [DEN_W-1:0] rem_in  [DIV_STAGES];
	logic [NUM_W-1:0] num_in  [DIV_STAGES];
	logic [DEN_W-1:0] den_in  [DIV_STAGES];
	quo_t             quo_in  [DIV_STAGES];
	logic [DEN_W-1:0] rem_out [DIV_STAGES];
	quo_t             quo_out [DIV_STAGES];
	logic [DEN_W-1:0] rem_s   [DIV_STAGES];
	quo_t             quo_s   [DIV_STAGES];
	logic [NUM_W-1:0] num_s   [DIV_STAGES-1];
	logic [DEN_W-1:0] den_s   [DIV_STAGES-1];

	function automatic logic [DEN_W+COORD_BITS-1:0] div_stage(input int g,
			input logic [DEN_W-1:0] rem, input logic [NUM_W-1:0] num,
			input logic [DEN_W-1:0] den, input quo_t quo);
		logic [DEN_W:0]   t;
		logic [DEN_W-1:0] r;
		quo_t             q;
		int               b;
		r = rem;
		q = quo;
		for (int j = 0; j < DIV_SPS; j++) begin
			b = COORD_BITS - 1 - (g * DIV_SPS + j);
			if (b >= 0) begin
				t = {r, num[b]};
				if (t >= {1'b0, den}) begin
					t = t - {1'b0, den};
					q[b] = 1'b1;
				end
				r = t[DEN_W-1:0];
			end
		end
		return {r, q};
	endfunction

	for (genvar g = 0; g < DIV_STAGES; g++) begin : g_stage
		if (g == 0) begin : g_first
			assign rem_in[g] = DEN_W'(dividend[NUM_W-1:COORD_BITS]);
			assign num_in[g] = dividend;
			assign den_in[g] = divisor;
			assign quo_in[g] = '0;
		end else begin : g_next
			assign rem_in[g] = rem_s[g-1];
			assign num_in[g] = num_s[g-1];
			assign den_in[g] = den_s[g-1];
			assign quo_in[g] = quo_s[g-1];
		end

		assign {rem_out[g], quo_out[g]} =
			div_stage(g, rem_in[g], num_in[g], den_in[g], quo_in[g]);

		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[g] <= rem_out[g];
				quo_s[g] <= quo_out[g];
			end
		end

		if (g < DIV_STAGES - 1) begin : g_pass
			always_ff @(posedge clk) begin
				if (en) begin
					num_s[g] <= num_in[g];
					den_s[g] <= den_in[g];
				end
			end
		end
	end

	assign quotient = quo_s[DIV_STAGES-1];

endmodule

// ----- rtl/nps_ser.sv -----
// holds one finished grid and sends its nine patches through the output register
module nps_ser (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           grid_valid,
	input  nps_pkg::grid_t                 grid,
	output logic                           take,
	output logic                           m_axis_tvalid,
	input  logic                           m_axis_tready,
	output logic [nps_pkg::OUT_DATA_W-1:0] m_axis_tdata,
	output logic                           m_axis_tlast
);
	import nps_pkg::*;

	logic                  busy_q;
	grid_t                 grid_q;
	logic [IDX_W-1:0]      idx_q;
	logic [1:0]            row_q;
	logic [1:0]            col_q;
	logic                  out_valid_q;
	logic [OUT_DATA_W-1:0] tdata_q;
	logic                  tlast_q;
	logic                  emit;
	logic                  fin;
	logic [OUT_DATA_W-1:0] data_c;

	function automatic edge_t pick(input axis_t a, input logic [1:0] k);
		edge_t e;
		unique case (k)
			2'd0: e = a.e0;
			2'd1: e = a.e1;
			2'd2: e = a.e2;
			2'd3: e = a.e3;
		endcase
		return e;
	endfunction

	assign emit = busy_q && (!out_valid_q || m_axis_tready);
	assign fin  = emit && (idx_q == IDX_W'(PATCH_COUNT - 1));
	assign take = !busy_q || fin;

	always_comb begin
		edge_t sl;
		edge_t st;
		edge_t sr;
		edge_t sb;
		edge_t dl;
		edge_t dt;
		edge_t dr;
		edge_t db;
		sl = pick(grid_q.sx, col_q);
		sr = pick(grid_q.sx, 2'(col_q + 2'd1));
		st = pick(grid_q.sy, row_q);
		sb = pick(grid_q.sy, 2'(row_q + 2'd1));
		dl = pick(grid_q.dx, col_q);
		dr = pick(grid_q.dx, 2'(col_q + 2'd1));
		dt = pick(grid_q.dy, row_q);
		db = pick(grid_q.dy, 2'(row_q + 2'd1));
		data_c = {{PAD_W{1'b0}}, db[OUT_W-1:0], dr[OUT_W-1:0], dt[OUT_W-1:0],
			dl[OUT_W-1:0], sb[OUT_W-1:0], sr[OUT_W-1:0], st[OUT_W-1:0],
			sl[OUT_W-1:0], idx_q};
		if (grid_q.empty) begin
			data_c = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			idx_q  <= '0;
			row_q  <= '0;
			col_q  <= '0;
		end else if (take && grid_valid) begin
			busy_q <= 1'b1;
			idx_q  <= '0;
			row_q  <= '0;
			col_q  <= '0;
		end else if (fin) begin
			busy_q <= 1'b0;
		end else if (emit) begin
			idx_q <= idx_q + 1'b1;
			if (col_q == 2'd2) begin
				col_q <= '0;
				row_q <= row_q + 1'b1;
			end else begin
				col_q <= col_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take && grid_valid) begin
			grid_q <= grid;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (emit) begin
			out_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			tdata_q <= data_c;
			tlast_q <= !grid_q.empty && (idx_q == IDX_W'(PATCH_COUNT - 1));
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = tdata_q;
	assign m_axis_tlast  = tlast_q;

endmodule

// ----- rtl/nine_patch_rect_split.sv -----
// top level: frame registers, pipeline control, fold-point stage and output
//
// channel   direction  item                                       handshake
// s_axis    in         source and destination rectangle           tvalid/tready
// m_axis    out        one patch: index, source and dest edges    tvalid/tready, tlast
// apb       in         frame widths, four registers at 0x0..0xc   psel/penable, pready
//
// an item passes three front stages, an eight-stage divider and one fold stage
// before the patch sequencer takes it
// each item yields nine patches, one per cycle unless the output stalls, through
// the single output register; the next item is taken as its last patch is sent
// reset clears the valid bits, the frame registers and the patch sequencer
// a stall at the output holds the patch sequencer; the stages keep filling until
// the last one holds a waiting item, then all hold; nothing is dropped or repeated
module nine_patch_rect_split (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           psel,
	input  logic                           penable,
	input  logic                           pwrite,
	input  logic [nps_pkg::ADDR_W-1:0]     paddr,
	input  logic [nps_pkg::APB_W-1:0]      pwdata,
	output logic [nps_pkg::APB_W-1:0]      prdata,
	output logic                           pready,
	input  logic                           s_axis_tvalid,
	output logic                           s_axis_tready,
	// source_left, source_top, source_right, source_bottom,
	// target_left, target_top, target_right, target_bottom
	input  logic [nps_pkg::IN_DATA_W-1:0]  s_axis_tdata,
	output logic                           m_axis_tvalid,
	input  logic                           m_axis_tready,
	// patch_index, out_src_left, out_src_top, out_src_right, out_src_bottom,
	// out_dst_left, out_dst_top, out_dst_right, out_dst_bottom, zero pad
	output logic [nps_pkg::OUT_DATA_W-1:0] m_axis_tdata,
	output logic                           m_axis_tlast
);
	import nps_pkg::*;

	frames_t          frames_q;
	reg_idx_t         reg_idx;
	logic [VLD_N-1:0] vld_q;
	logic             en;
	logic             take;
	grid_t            grid_s3;
	logic [NUM_W-1:0] num_x_s3;
	logic [NUM_W-1:0] num_y_s3;
	logic [DEN_W-1:0] den_x_s3;
	logic [DEN_W-1:0] den_y_s3;
	quo_t             quo_x;
	quo_t             quo_y;
	grid_t            grid_d [DIV_STAGES];
	grid_t            grid_c;
	grid_t            grid_sf;

	function automatic edge_t midpoint(input edge_t lo, input edge_t hi);
		edge_t s;
		s = lo + hi;
		if (s[EDGE_W-1] && s[0]) begin
			s = s + edge_t'(1);
		end
		return s >>> 1;
	endfunction

	function automatic axis_t settle(input axis_t a, input quo_t q);
		axis_t r;
		edge_t p;
		r = a;
		p = a.zero_sum ? midpoint(a.e0, a.e3) : a.e0 + edge_t'({2'b00, q});
		if (a.fold) begin
			r.e1 = p;
			r.e2 = p;
		end
		return r;
	endfunction

	// configuration port
	assign reg_idx = reg_idx_t'(paddr[3:2]);
	assign pready  = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frames_q <= '0;
		end else if (psel && penable && pwrite && pready) begin
			unique case (reg_idx)
				REG_FRAME_LEFT:   frames_q.left   <= pwdata[FRAME_BITS-1:0];
				REG_FRAME_TOP:    frames_q.top    <= pwdata[FRAME_BITS-1:0];
				REG_FRAME_RIGHT:  frames_q.right  <= pwdata[FRAME_BITS-1:0];
				REG_FRAME_BOTTOM: frames_q.bottom <= pwdata[FRAME_BITS-1:0];
			endcase
		end
	end

	always_comb begin
		unique case (reg_idx)
			REG_FRAME_LEFT:   prdata = APB_W'(frames_q.left);
			REG_FRAME_TOP:    prdata = APB_W'(frames_q.top);
			REG_FRAME_RIGHT:  prdata = APB_W'(frames_q.right);
			REG_FRAME_BOTTOM: prdata = APB_W'(frames_q.bottom);
		endcase
	end

	// pipeline control
	assign en            = !vld_q[VLD_N-1] || take;
	assign s_axis_tready = en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (en) begin
			vld_q <= {vld_q[VLD_N-2:0], s_axis_tvalid};
		end
	end

	nps_front u_front (
		.clk      (clk),
		.en       (en),
		.in_data  (s_axis_tdata),
		.frames   (frames_q),
		.grid_s3  (grid_s3),
		.num_x_s3 (num_x_s3),
		.num_y_s3 (num_y_s3),
		.den_x_s3 (den_x_s3),
		.den_y_s3 (den_y_s3)
	);

	nps_div u_div_x (
		.clk      (clk),
		.en       (en),
		.dividend (num_x_s3),
		.divisor  (den_x_s3),
		.quotient (quo_x)
	);

	nps_div u_div_y (
		.clk      (clk),
		.en       (en),
		.dividend (num_y_s3),
		.divisor  (den_y_s3),
		.quotient (quo_y)
	);

	// grid travels beside the dividers
	always_ff @(posedge clk) begin
		if (en) begin
			grid_d[0] <= grid_s3;
			for (int i = 1; i < DIV_STAGES; i++) begin
				grid_d[i] <= grid_d[i-1];
			end
		end
	end

	// fold stage
	always_comb begin
		grid_c    = grid_d[DIV_STAGES-1];
		grid_c.dx = settle(grid_d[DIV_STAGES-1].dx, quo_x);
		grid_c.dy = settle(grid_d[DIV_STAGES-1].dy, quo_y);
	end

	always_ff @(posedge clk) begin
		if (en) begin
			grid_sf <= grid_c;
		end
	end

	nps_ser u_ser (
		.clk           (clk),
		.arst_n        (arst_n),
		.grid_valid    (vld_q[VLD_N-1]),
		.grid          (grid_sf),
		.take          (take),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tlast  (m_axis_tlast)
	);

endmodule
